### design/wlf_pkg.sv
`timescale 1ns / 1ps

package wlf_pkg;

   localparam int MAX_WINDOW_DEF  = 64;
   localparam int MAX_FRAME_DEF   = 1024;
   localparam int SAMPLE_BITS_DEF = 12;

   localparam int SAMPLE_W = 12;
   localparam int INDEX_W  = 10;
   localparam int VALUE_W  = 32;
   localparam int PEAK_W   = 31;
   localparam int WLEN_W   = 7;
   localparam int FLEN_W   = 11;

   localparam int REQ_DATA_W   = ((SAMPLE_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 3 * VALUE_W + INDEX_W + PEAK_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_USER_W   = 2;
   localparam int USER_FRAME_LAST = 0;
   localparam int USER_DEGENERATE = 1;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = FLEN_W;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_LEN = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_LEN  = 1'd1;

   localparam logic [WLEN_W-1:0] WINDOW_LEN_RESET = 7'd30;
   localparam logic [FLEN_W-1:0] FRAME_LEN_RESET  = 11'd1000;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ACC_XX,
      ST_ACC_XY,
      ST_ACC_SUM,
      ST_FIT_NXX,
      ST_FIT_SXX,
      ST_FIT_NXY,
      ST_FIT_SXY,
      ST_FIT_NUM,
      ST_FIT_SLOPE,
      ST_SLOPE_WAIT,
      ST_ICPT_MUL,
      ST_ICPT_SUB,
      ST_ICPT_DIV,
      ST_ICPT_WAIT,
      ST_PT_MUL,
      ST_PT_OUT
   } wlf_state_type;

endpackage

### design/wlf_mul.sv
`timescale 1ns / 1ps

module wlf_mul #(
   parameter int MA_W = 33,
   parameter int MB_W = 20
) (
   input  logic                           clock,
   input  logic signed [MA_W-1:0]         op_a,
   input  logic signed [MB_W-1:0]         op_b,
   output logic signed [MA_W+MB_W-1:0]    prod
);

   logic signed [MA_W+MB_W-1:0] prod_ff;
   logic signed [MA_W+MB_W-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

### design/wlf_div.sv
`timescale 1ns / 1ps

module wlf_div #(
   parameter int D_W = 50,
   parameter int V_W = 34
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic signed [D_W-1:0] dividend,
   input  logic        [V_W-1:0] divisor,
   output logic                  done,
   output logic signed [D_W:0]   quotient
);

   localparam int CW = $clog2(D_W + 1);

   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [V_W-1:0] rem_ff, rem_in;
   logic [D_W-1:0] quo_ff, quo_in;
   logic [V_W-1:0] dvs_ff, dvs_in;
   logic           neg_ff, neg_in;

   logic [D_W-1:0] mag;
   logic [V_W:0]   shifted;
   logic [V_W+1:0] diff;
   logic signed [D_W:0] qpos;

   assign mag     = dividend[D_W-1] ? D_W'(-dividend) : dividend;
   assign shifted = {rem_ff, quo_ff[D_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(D_W);
         rem_in  = '0;
         quo_in  = mag;
         dvs_in  = divisor;
         neg_in  = dividend[D_W-1];
      end else if (busy_ff) begin
         if (!diff[V_W+1]) begin
            rem_in = diff[V_W-1:0];
            quo_in = {quo_ff[D_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[V_W-1:0];
            quo_in = {quo_ff[D_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign qpos     = $signed({1'b0, quo_ff});
   assign quotient = neg_ff ? -qpos : qpos;
   assign done     = done_ff;

endmodule

### design/windowed_linear_fit_max.sv
// Piecewise least-squares line fit over frames of ADC samples. Each sample sits at its index
// within the frame; the frame is cut into windows of window_len samples (the last one may be
// shorter) and each closed window yields one item per index with the fitted value, the exact
// integer slope and intercept, the running maximum since reset and end-of-window/frame marks
// (tlast = window end, tuser = frame end, degenerate). A sample that closes no window is
// accepted, then the sums are updated in three steps (ACC_XX, ACC_XY, ACC_SUM) through the one
// shared multiplier. A sample that closes a window holds req_tready low through the fit and
// until every fitted point is loaded for output, each waiting for a free output slot. D = 50 at
// default parameters is the dividend width worked one quotient bit per cycle by the shared
// restoring divider, once for the slope (skipped if degenerate) and once for the intercept.
`timescale 1ns / 1ps

module windowed_linear_fit_max #(
   parameter int MAX_WINDOW  = wlf_pkg::MAX_WINDOW_DEF,
   parameter int MAX_FRAME   = wlf_pkg::MAX_FRAME_DEF,
   parameter int SAMPLE_BITS = wlf_pkg::SAMPLE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: sample[11:0]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [wlf_pkg::REQ_DATA_W-1:0]     req_tdata,
   // rsp_tdata: fitted_value[31:0], sample_index[41:32], slope[73:42],
   //            intercept[105:74], running_max[136:106]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [wlf_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tlast,
   // rsp_tuser: frame_last[0], degenerate[1]
   output logic [wlf_pkg::RSP_USER_W-1:0]     rsp_tuser,
   input  logic                               csr_we,
   input  logic [wlf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wlf_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int VALUE_W = wlf_pkg::VALUE_W;
   localparam int WCAP    = (MAX_WINDOW < 127) ? MAX_WINDOW : 127;
   localparam int FCAP    = (MAX_FRAME < 2047) ? MAX_FRAME : 2047;
   localparam int POS_W   = $clog2(FCAP);
   localparam int CNT_W   = $clog2(WCAP + 1);
   localparam int Y_W     = (SAMPLE_BITS < wlf_pkg::SAMPLE_W) ? SAMPLE_BITS : wlf_pkg::SAMPLE_W;
   localparam int SX_W    = POS_W + CNT_W;
   localparam int SY_W    = Y_W + CNT_W;
   localparam int SXX_W   = 2 * POS_W + CNT_W;
   localparam int SXY_W   = POS_W + Y_W + CNT_W;
   localparam int DEN_W   = 2 * CNT_W + 2 * POS_W;
   localparam int NUM_W   = 2 * CNT_W + POS_W + Y_W + 1;
   localparam int BNUM_W  = VALUE_W + SX_W + 1;
   localparam int D_W     = (NUM_W > BNUM_W) ? NUM_W : BNUM_W;
   localparam int Q_W     = D_W + 1;
   localparam int MA_0    = (SXY_W + 1 > VALUE_W) ? SXY_W + 1 : VALUE_W;
   localparam int MA_W    = (SXX_W + 1 > MA_0) ? SXX_W + 1 : MA_0;
   localparam int MB_0    = (SY_W > SX_W) ? SY_W : SX_W;
   localparam int MB_W    = MB_0 + 1;
   localparam int P_W     = MA_W + MB_W;
   localparam int F_W     = P_W + 1;
   localparam int FLW     = POS_W + 1;
   localparam int IXW     = (POS_W > wlf_pkg::INDEX_W) ? POS_W : wlf_pkg::INDEX_W;

   wlf_pkg::wlf_state_type state_ff, state_in;

   logic [wlf_pkg::WLEN_W-1:0] window_len_ff, window_len_in;
   logic [wlf_pkg::FLEN_W-1:0] frame_len_ff, frame_len_in;
   logic [POS_W-1:0]  frame_pos_ff, frame_pos_in;
   logic [POS_W-1:0]  window_start_ff, window_start_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SX_W-1:0]   sx_ff, sx_in;
   logic [SY_W-1:0]   sy_ff, sy_in;
   logic [SXX_W-1:0]  sxx_ff, sxx_in;
   logic [SXY_W-1:0]  sxy_ff, sxy_in;
   logic [wlf_pkg::PEAK_W-1:0] peak_ff, peak_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [POS_W-1:0]  x_ff, x_in;
   logic [Y_W-1:0]    y_ff, y_in;
   logic              frame_end_ff, frame_end_in;
   logic signed [D_W-1:0] t_ff, t_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic              degen_ff, degen_in;
   logic signed [VALUE_W-1:0] slope_ff, slope_in;
   logic signed [VALUE_W-1:0] icpt_ff, icpt_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [wlf_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [wlf_pkg::RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   logic signed [MA_W-1:0] mul_a;
   logic signed [MB_W-1:0] mul_b;
   logic signed [P_W-1:0]  mul_prod;
   logic                   div_start;
   logic signed [D_W-1:0]  div_dividend;
   logic [DEN_W-1:0]       div_divisor;
   logic                   div_done;
   logic signed [Q_W-1:0]  div_q;

   logic [CNT_W-1:0]  wlen;
   logic [FLW-1:0]    flen;
   logic [CNT_W-1:0]  count_next;
   logic              frame_end;
   logic [POS_W-1:0]  idx;
   logic [IXW-1:0]    idx_wide;
   logic              pt_last;
   logic signed [D_W-1:0] t_diff;
   logic signed [VALUE_W-1:0] q_sat;
   logic signed [F_W-1:0] f_sum;
   logic signed [VALUE_W-1:0] f_sat;
   logic [wlf_pkg::PEAK_W-1:0] peak_new;
   logic              out_free;

   wlf_mul #(
      .MA_W (MA_W),
      .MB_W (MB_W)
   ) u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_prod)
   );

   wlf_div #(
      .D_W (D_W),
      .V_W (DEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      if (window_len_ff < wlf_pkg::WLEN_W'(2)) begin
         wlen = CNT_W'(2);
      end else if (window_len_ff > wlf_pkg::WLEN_W'(WCAP)) begin
         wlen = CNT_W'(WCAP);
      end else begin
         wlen = CNT_W'(window_len_ff);
      end
      if (frame_len_ff < wlf_pkg::FLEN_W'(2)) begin
         flen = FLW'(2);
      end else if (frame_len_ff > wlf_pkg::FLEN_W'(FCAP)) begin
         flen = FLW'(FCAP);
      end else begin
         flen = FLW'(frame_len_ff);
      end
   end

   assign count_next = count_ff + CNT_W'(1);
   assign frame_end  = ({1'b0, frame_pos_ff} + FLW'(1)) >= flen;
   assign idx        = window_start_ff + POS_W'(k_ff);
   assign idx_wide   = IXW'(idx);
   assign pt_last    = (k_ff == count_ff - CNT_W'(1));
   assign t_diff     = t_ff - $signed(mul_prod[D_W-1:0]);

   always_comb begin
      if (&div_q[Q_W-1:VALUE_W-1] || ~|div_q[Q_W-1:VALUE_W-1]) begin
         q_sat = div_q[VALUE_W-1:0];
      end else begin
         q_sat = {div_q[Q_W-1], {(VALUE_W-1){~div_q[Q_W-1]}}};
      end
   end

   assign f_sum = F_W'(mul_prod) + F_W'(icpt_ff);

   always_comb begin
      if (&f_sum[F_W-1:VALUE_W-1] || ~|f_sum[F_W-1:VALUE_W-1]) begin
         f_sat = f_sum[VALUE_W-1:0];
      end else begin
         f_sat = {f_sum[F_W-1], {(VALUE_W-1){~f_sum[F_W-1]}}};
      end
   end

   assign peak_new = (f_sat > $signed({1'b0, peak_ff})) ? f_sat[wlf_pkg::PEAK_W-1:0] : peak_ff;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in        = state_ff;
      window_len_in   = window_len_ff;
      frame_len_in    = frame_len_ff;
      frame_pos_in    = frame_pos_ff;
      window_start_in = window_start_ff;
      count_in        = count_ff;
      sx_in           = sx_ff;
      sy_in           = sy_ff;
      sxx_in          = sxx_ff;
      sxy_in          = sxy_ff;
      peak_in         = peak_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      x_in            = x_ff;
      y_in            = y_ff;
      frame_end_in    = frame_end_ff;
      t_in            = t_ff;
      den_in          = den_ff;
      degen_in        = degen_ff;
      slope_in        = slope_ff;
      icpt_in         = icpt_ff;
      k_in            = k_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_user_in     = rsp_user_ff;
      mul_a           = '0;
      mul_b           = '0;
      div_start       = 1'b0;
      div_dividend    = t_ff;
      div_divisor     = den_ff;

      unique case (state_ff)
         wlf_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               x_in     = frame_pos_ff;
               y_in     = req_tdata[Y_W-1:0];
               state_in = wlf_pkg::ST_ACC_XX;
            end
         end
         wlf_pkg::ST_ACC_XX: begin
            mul_a    = MA_W'(x_ff);
            mul_b    = MB_W'(x_ff);
            state_in = wlf_pkg::ST_ACC_XY;
         end
         wlf_pkg::ST_ACC_XY: begin
            mul_a    = MA_W'(x_ff);
            mul_b    = MB_W'(y_ff);
            sxx_in   = sxx_ff + mul_prod[SXX_W-1:0];
            state_in = wlf_pkg::ST_ACC_SUM;
         end
         wlf_pkg::ST_ACC_SUM: begin
            sxy_in       = sxy_ff + mul_prod[SXY_W-1:0];
            sx_in        = sx_ff + SX_W'(x_ff);
            sy_in        = sy_ff + SY_W'(y_ff);
            count_in     = count_next;
            frame_end_in = frame_end;
            if (count_next >= wlen || frame_end) begin
               state_in = wlf_pkg::ST_FIT_NXX;
            end else begin
               frame_pos_in = frame_pos_ff + POS_W'(1);
               state_in     = wlf_pkg::ST_IDLE;
            end
         end
         wlf_pkg::ST_FIT_NXX: begin
            mul_a    = MA_W'(sxx_ff);
            mul_b    = MB_W'(count_ff);
            state_in = wlf_pkg::ST_FIT_SXX;
         end
         wlf_pkg::ST_FIT_SXX: begin
            mul_a    = MA_W'(sx_ff);
            mul_b    = MB_W'(sx_ff);
            t_in     = $signed(mul_prod[D_W-1:0]);
            state_in = wlf_pkg::ST_FIT_NXY;
         end
         wlf_pkg::ST_FIT_NXY: begin
            mul_a    = MA_W'(sxy_ff);
            mul_b    = MB_W'(count_ff);
            den_in   = t_diff[DEN_W-1:0];
            state_in = wlf_pkg::ST_FIT_SXY;
         end
         wlf_pkg::ST_FIT_SXY: begin
            mul_a    = MA_W'(sx_ff);
            mul_b    = MB_W'(sy_ff);
            t_in     = $signed(mul_prod[D_W-1:0]);
            state_in = wlf_pkg::ST_FIT_NUM;
         end
         wlf_pkg::ST_FIT_NUM: begin
            t_in     = t_diff;
            state_in = wlf_pkg::ST_FIT_SLOPE;
         end
         wlf_pkg::ST_FIT_SLOPE: begin
            degen_in = (den_ff == '0);
            if (den_ff == '0) begin
               slope_in = '0;
               state_in = wlf_pkg::ST_ICPT_MUL;
            end else begin
               div_start = 1'b1;
               state_in  = wlf_pkg::ST_SLOPE_WAIT;
            end
         end
         wlf_pkg::ST_SLOPE_WAIT: begin
            if (div_done) begin
               slope_in = q_sat;
               state_in = wlf_pkg::ST_ICPT_MUL;
            end
         end
         wlf_pkg::ST_ICPT_MUL: begin
            mul_a    = MA_W'(slope_ff);
            mul_b    = MB_W'(sx_ff);
            state_in = wlf_pkg::ST_ICPT_SUB;
         end
         wlf_pkg::ST_ICPT_SUB: begin
            t_in     = $signed(D_W'(sy_ff)) - $signed(mul_prod[D_W-1:0]);
            state_in = wlf_pkg::ST_ICPT_DIV;
         end
         wlf_pkg::ST_ICPT_DIV: begin
            div_start   = 1'b1;
            div_divisor = DEN_W'(count_ff);
            state_in    = wlf_pkg::ST_ICPT_WAIT;
         end
         wlf_pkg::ST_ICPT_WAIT: begin
            if (div_done) begin
               icpt_in  = q_sat;
               k_in     = '0;
               state_in = wlf_pkg::ST_PT_MUL;
            end
         end
         wlf_pkg::ST_PT_MUL: begin
            mul_a    = MA_W'(slope_ff);
            mul_b    = MB_W'(idx);
            state_in = wlf_pkg::ST_PT_OUT;
         end
         wlf_pkg::ST_PT_OUT: begin
            mul_a = MA_W'(slope_ff);
            mul_b = MB_W'(idx);
            if (out_free) begin
               rsp_valid_in = 1'b1;
               peak_in      = peak_new;
               rsp_data_in  = wlf_pkg::RSP_DATA_W'({peak_new, icpt_ff, slope_ff,
                                 idx_wide[wlf_pkg::INDEX_W-1:0], f_sat});
               rsp_last_in  = pt_last;
               rsp_user_in[wlf_pkg::USER_FRAME_LAST] = pt_last && frame_end_ff;
               rsp_user_in[wlf_pkg::USER_DEGENERATE] = degen_ff;
               if (pt_last) begin
                  sx_in    = '0;
                  sy_in    = '0;
                  sxx_in   = '0;
                  sxy_in   = '0;
                  count_in = '0;
                  if (frame_end_ff) begin
                     frame_pos_in    = '0;
                     window_start_in = '0;
                  end else begin
                     frame_pos_in    = frame_pos_ff + POS_W'(1);
                     window_start_in = frame_pos_ff + POS_W'(1);
                  end
                  state_in = wlf_pkg::ST_IDLE;
               end else begin
                  k_in     = k_ff + CNT_W'(1);
                  state_in = wlf_pkg::ST_PT_MUL;
               end
            end
         end
         default: begin
            state_in = wlf_pkg::ST_IDLE;
         end
      endcase

      if (csr_we) begin
         if (csr_index == wlf_pkg::REG_WINDOW_LEN) begin
            window_len_in = csr_wdata[wlf_pkg::WLEN_W-1:0];
         end
         if (csr_index == wlf_pkg::REG_FRAME_LEN) begin
            frame_len_in = csr_wdata[wlf_pkg::FLEN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wlf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff   <= wlf_pkg::WINDOW_LEN_RESET;
         frame_len_ff    <= wlf_pkg::FRAME_LEN_RESET;
         frame_pos_ff    <= '0;
         window_start_ff <= '0;
         count_ff        <= '0;
         sx_ff           <= '0;
         sy_ff           <= '0;
         sxx_ff          <= '0;
         sxy_ff          <= '0;
         peak_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         window_len_ff   <= window_len_in;
         frame_len_ff    <= frame_len_in;
         frame_pos_ff    <= frame_pos_in;
         window_start_ff <= window_start_in;
         count_ff        <= count_in;
         sx_ff           <= sx_in;
         sy_ff           <= sy_in;
         sxx_ff          <= sxx_in;
         sxy_ff          <= sxy_in;
         peak_ff         <= peak_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      y_ff         <= y_in;
      frame_end_ff <= frame_end_in;
      t_ff         <= t_in;
      den_ff       <= den_in;
      degen_ff     <= degen_in;
      slope_ff     <= slope_in;
      icpt_ff      <= icpt_in;
      k_ff         <= k_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_user_ff  <= rsp_user_in;
   end

   assign req_tready = (state_ff == wlf_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(WCAP))
      else $error("window count beyond maximum window");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_start |-> div_divisor != '0)
      else $error("division started with zero divisor");

   a_frame_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[wlf_pkg::USER_FRAME_LAST] |-> rsp_tlast)
      else $error("frame end item not marked as window end");

   a_wait_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wlf_pkg::ST_SLOPE_WAIT || state_ff == wlf_pkg::ST_ICPT_WAIT) |-> !div_start)
      else $error("divider restarted while waiting for quotient");
`endif

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int CYCLE_LIMIT  = 4000000;
   localparam int PHASE_QUIET  = 20;
   localparam int END_QUIET    = 300;

   localparam int IDX_LO   = wlf_pkg::VALUE_W;
   localparam int SLOPE_LO = IDX_LO + wlf_pkg::INDEX_W;
   localparam int ICPT_LO  = SLOPE_LO + wlf_pkg::VALUE_W;
   localparam int PEAK_LO  = ICPT_LO + wlf_pkg::VALUE_W;

   typedef struct {
      logic signed [wlf_pkg::VALUE_W-1:0] fitted;
      logic [wlf_pkg::INDEX_W-1:0]        index;
      logic signed [wlf_pkg::VALUE_W-1:0] slope;
      logic signed [wlf_pkg::VALUE_W-1:0] intercept;
      logic [wlf_pkg::PEAK_W-1:0]         peak;
      logic                               win_last;
      logic                               frame_last;
      logic                               degen;
   } fit_point_type;

   logic                             clock;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [wlf_pkg::REQ_DATA_W-1:0]   req_tdata = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [wlf_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                             rsp_tlast;
   logic [wlf_pkg::RSP_USER_W-1:0]   rsp_tuser;
   logic                             csr_we = 1'b0;
   logic [wlf_pkg::CSR_IDX_W-1:0]    csr_index = '0;
   logic [wlf_pkg::CSR_DATA_W-1:0]   csr_wdata = '0;

   windowed_linear_fit_max u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // fit predictor state
   int unsigned reg_window;
   int unsigned reg_frame;
   int unsigned fit_frame_pos;
   int unsigned fit_win_start;
   int unsigned fit_win_count;
   longint      acc_x, acc_y, acc_xx, acc_xy;
   longint      fit_peak;
   fit_point_type pending_fits[$];

   int  mismatch_cnt = 0;
   int  cycle_cnt = 0;
   bit  tx_idle_on = 1'b1;
   bit  rx_idle_on = 1'b1;
   int  rsp_hold_len = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint clip32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic int unsigned clamp_len(input int unsigned v, input int unsigned hi);
      if (v < 2) return 2;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void reset_fit_model();
      reg_window    = 32'(wlf_pkg::WINDOW_LEN_RESET);
      reg_frame     = 32'(wlf_pkg::FRAME_LEN_RESET);
      fit_frame_pos = 0;
      fit_win_start = 0;
      fit_win_count = 0;
      acc_x = 0;
      acc_y = 0;
      acc_xx = 0;
      acc_xy = 0;
      fit_peak = 0;
   endfunction

   // accumulate one sample; on window close queue one fit point per index
   function automatic void predict_fits(input logic [wlf_pkg::SAMPLE_W-1:0] s);
      int unsigned wl, fl, k, idx;
      longint      x, y, n, num, den, a, b, f;
      bit          frame_end, degen;
      fit_point_type p;
      wl = clamp_len(reg_window, wlf_pkg::MAX_WINDOW_DEF);
      fl = clamp_len(reg_frame, wlf_pkg::MAX_FRAME_DEF);
      x = longint'(fit_frame_pos);
      y = longint'(s);
      acc_x  += x;
      acc_y  += y;
      acc_xx += x * x;
      acc_xy += x * y;
      fit_win_count++;
      frame_end = (fit_frame_pos + 1 >= fl);
      if (fit_win_count < wl && !frame_end) begin
         fit_frame_pos++;
         return;
      end
      n   = longint'(fit_win_count);
      num = n * acc_xy - acc_x * acc_y;
      den = n * acc_xx - acc_x * acc_x;
      degen = (den == 0);
      a = degen ? 64'sd0 : clip32(num / den);
      b = clip32((acc_y - a * acc_x) / n);
      for (k = 0; k < fit_win_count; k++) begin
         idx = fit_win_start + k;
         f = clip32(a * longint'(idx) + b);
         if (f > fit_peak) fit_peak = f;
         p.fitted     = f[wlf_pkg::VALUE_W-1:0];
         p.index      = idx[wlf_pkg::INDEX_W-1:0];
         p.slope      = a[wlf_pkg::VALUE_W-1:0];
         p.intercept  = b[wlf_pkg::VALUE_W-1:0];
         p.peak       = fit_peak[wlf_pkg::PEAK_W-1:0];
         p.win_last   = (k + 1 == fit_win_count);
         p.frame_last = p.win_last && frame_end;
         p.degen      = degen;
         pending_fits.push_back(p);
      end
      acc_x = 0;
      acc_y = 0;
      acc_xx = 0;
      acc_xy = 0;
      fit_win_count = 0;
      if (frame_end) begin
         fit_frame_pos = 0;
         fit_win_start = 0;
      end else begin
         fit_frame_pos++;
         fit_win_start = fit_frame_pos;
      end
   endfunction

   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic logic [wlf_pkg::SAMPLE_W-1:0] rand_sample();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return wlf_pkg::SAMPLE_W'($urandom_range(0, 4095));
   endfunction

   task automatic send_sample(input logic [wlf_pkg::SAMPLE_W-1:0] s);
      int gap;
      gap = tx_idle_on ? idle_cycles() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(wlf_pkg::REQ_DATA_W - wlf_pkg::SAMPLE_W){1'b0}}, s};
      do @(posedge clock); while (req_tready !== 1'b1);
      predict_fits(s);
   endtask

   task automatic write_reg(input logic [wlf_pkg::CSR_IDX_W-1:0] idx,
                            input logic [wlf_pkg::CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == wlf_pkg::REG_WINDOW_LEN) reg_window = 32'(val[wlf_pkg::WLEN_W-1:0]);
      else reg_frame = 32'(val[wlf_pkg::FLEN_W-1:0]);
      @(posedge clock);
   endtask

   task automatic drain_fits(input int quiet);
      req_tvalid <= 1'b0;
      while (pending_fits.size() != 0) @(posedge clock);
      repeat (quiet) @(posedge clock);
   endtask

   task automatic check_field(input string what, input logic signed [63:0] exp_v,
                              input logic signed [63:0] act_v);
      if (exp_v !== act_v) begin
         mismatch_cnt++;
         $display("%0t %s: expected %0d actual %0d", $time, what, exp_v, act_v);
      end
   endtask

   // response ready: random stalls, plus a long hold-off when requested
   initial begin : rsp_ready_drive
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_len > 0) begin
            stall_left = rsp_hold_len;
            rsp_hold_len = 0;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (rx_idle_on) stall_left = idle_cycles();
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      fit_point_type e;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (pending_fits.size() == 0) begin
            mismatch_cnt++;
            $display("%0t unexpected item: expected none actual index %0d value %0d",
                     $time, rsp_tdata[SLOPE_LO-1:IDX_LO],
                     $signed(rsp_tdata[wlf_pkg::VALUE_W-1:0]));
         end else begin
            e = pending_fits.pop_front();
            check_field("fitted_value", 64'(e.fitted), 64'($signed(rsp_tdata[IDX_LO-1:0])));
            check_field("sample_index", 64'(e.index), 64'(rsp_tdata[SLOPE_LO-1:IDX_LO]));
            check_field("slope", 64'(e.slope), 64'($signed(rsp_tdata[ICPT_LO-1:SLOPE_LO])));
            check_field("intercept", 64'(e.intercept),
                        64'($signed(rsp_tdata[PEAK_LO-1:ICPT_LO])));
            check_field("running_max", 64'(e.peak),
                        64'(rsp_tdata[PEAK_LO+wlf_pkg::PEAK_W-1:PEAK_LO]));
            check_field("window_last", 64'(e.win_last), 64'(rsp_tlast));
            check_field("frame_last", 64'(e.frame_last),
                        64'(rsp_tuser[wlf_pkg::USER_FRAME_LAST]));
            check_field("degenerate", 64'(e.degen),
                        64'(rsp_tuser[wlf_pkg::USER_DEGENERATE]));
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic test_reset_values();
      repeat (64) send_sample(rand_sample());
      drain_fits(PHASE_QUIET);
   endtask

   task automatic test_length_clamps();
      // below-range lengths count as 2
      write_reg(wlf_pkg::REG_WINDOW_LEN, 11'd0);
      write_reg(wlf_pkg::REG_FRAME_LEN, 11'd1);
      send_sample(12'hFFF);
      send_sample(12'h000);
      send_sample(12'h000);
      send_sample(12'hFFF);
      drain_fits(PHASE_QUIET);
      write_reg(wlf_pkg::REG_WINDOW_LEN, 11'd1);
      write_reg(wlf_pkg::REG_FRAME_LEN, 11'd0);
      send_sample(12'h000);
      send_sample(12'h000);
      drain_fits(PHASE_QUIET);
      // above-range lengths clamp to the maxima
      write_reg(wlf_pkg::REG_WINDOW_LEN, 11'd127);
      write_reg(wlf_pkg::REG_FRAME_LEN, 11'd2047);
      repeat (3) send_sample(rand_sample());
      drain_fits(PHASE_QUIET);
      // shrink frame below the current index: next sample closes the window
      write_reg(wlf_pkg::REG_FRAME_LEN, 11'd3);
      send_sample(12'hABC);
      drain_fits(PHASE_QUIET);
   endtask

   task automatic test_single_point_window();
      write_reg(wlf_pkg::REG_WINDOW_LEN, 11'd2);
      write_reg(wlf_pkg::REG_FRAME_LEN, 11'd3);
      while (fit_frame_pos != 0) send_sample(12'h800);
      send_sample(12'hFFF);
      send_sample(12'h000);
      send_sample(12'hFFF);
      drain_fits(PHASE_QUIET);
   endtask

   task automatic test_window_write_mid();
      write_reg(wlf_pkg::REG_WINDOW_LEN, 11'd8);
      write_reg(wlf_pkg::REG_FRAME_LEN, 11'd100);
      send_sample(12'h123);
      send_sample(12'hFFF);
      send_sample(12'h001);
      drain_fits(PHASE_QUIET);
      write_reg(wlf_pkg::REG_WINDOW_LEN, 11'd3);
      send_sample(12'h7FF);
      drain_fits(PHASE_QUIET);
   endtask

   task automatic test_sample_extremes();
      write_reg(wlf_pkg::REG_WINDOW_LEN, 11'd2);
      write_reg(wlf_pkg::REG_FRAME_LEN, 11'd1024);
      send_sample(12'h000);
      send_sample(12'hFFF);
      send_sample(12'hFFF);
      send_sample(12'h000);
      send_sample(12'hFFF);
      send_sample(12'hFFF);
      send_sample(12'h000);
      send_sample(12'h000);
      send_sample(12'h555);
      send_sample(12'hAAA);
      drain_fits(PHASE_QUIET);
   endtask

   task automatic test_output_backpressure();
      write_reg(wlf_pkg::REG_WINDOW_LEN, 11'd8);
      write_reg(wlf_pkg::REG_FRAME_LEN, 11'd1024);
      tx_idle_on = 1'b0;
      rsp_hold_len = 800;
      repeat (48) send_sample(rand_sample());
      drain_fits(PHASE_QUIET);
      tx_idle_on = 1'b1;
   endtask

   task automatic test_random_settings();
      int wl_set[6];
      int fl_set[6];
      int cnt_set[6];
      int wl, fl, cnt;
      wl_set  = '{2, 64, 'h7C5, 5, 'h783, 17};
      fl_set  = '{1024, 2047, 17, 1000, 2, 300};
      cnt_set = '{20, 70, 20, 15, 10, 20};
      for (int ph = 0; ph < 8; ph++) begin
         if (ph < 6) begin
            wl  = wl_set[ph];
            fl  = fl_set[ph];
            cnt = cnt_set[ph];
         end else begin
            wl  = $urandom_range(0, 2047);
            fl  = $urandom_range(0, 2047);
            cnt = 10;
         end
         tx_idle_on = (ph % 3 != 2);
         rx_idle_on = tx_idle_on;
         write_reg(wlf_pkg::REG_WINDOW_LEN, wl[wlf_pkg::CSR_DATA_W-1:0]);
         write_reg(wlf_pkg::REG_FRAME_LEN, fl[wlf_pkg::CSR_DATA_W-1:0]);
         repeat (cnt) send_sample(rand_sample());
         drain_fits(PHASE_QUIET);
      end
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
   endtask

   initial begin
      reset_fit_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_length_clamps();
      test_single_point_window();
      test_window_write_mid();
      test_sample_extremes();
      test_output_backpressure();
      test_random_settings();
      drain_fits(END_QUIET);
      if (mismatch_cnt == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
